>>> src/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared widths and the data record handed between the cells of the RGB to
// HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned RGB_W     = 3 * CHAN_W;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned HUE_W     = FRAC_W;
  localparam int unsigned SAT_W     = FRAC_W + 1;
  localparam int unsigned HUE_DIV_W = 11;
  localparam int unsigned NUM_CELLS = FRAC_W;
  localparam int unsigned DEPTH     = NUM_CELLS + 1;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  typedef struct packed {
    logic                  gray;
    logic [HUE_DIV_W-1:0]  hue_rem;
    logic [HUE_DIV_W-1:0]  hue_div;
    logic [HUE_W-1:0]      hue_q;
    logic [CHAN_W-1:0]     sat_rem;
    logic [CHAN_W-1:0]     value;
    logic                  sat_int;
    logic [FRAC_W-1:0]     sat_q;
  } cell_data_t;

endpackage

`default_nettype wire

>>> src/rhc_if.sv
// ----------------------------------------------------------------------------
// rgb_if / hsv_if
// Valid/ready channels carrying one packed color and one HSV result.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgb_if;
  logic                       valid;
  logic                       ready;
  logic [rhc_pkg::RGB_W-1:0]  rgb_word;

  modport source (output valid, output rgb_word, input ready);
  modport sink   (input valid, input rgb_word, output ready);
endinterface

interface hsv_if;
  logic                        valid;
  logic                        ready;
  logic [rhc_pkg::HUE_W-1:0]   hue_frac;
  logic [rhc_pkg::SAT_W-1:0]   sat_frac;
  logic [rhc_pkg::CHAN_W-1:0]  value_level;

  modport source (output valid, output hue_frac, output sat_frac, output value_level,
                  input ready);
  modport sink   (input valid, input hue_frac, input sat_frac, input value_level,
                  output ready);
endinterface

`default_nettype wire

>>> src/rgb_to_hsv_convert_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_top
// Fixed-point RGB to HSV converter built as a row of division cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one packed color per transaction (red in bits 23..16).
//   out_ch carries hue_frac (0.16 turn), sat_frac (65536 = 1.0) and
//   value_level (largest channel byte) per transaction, in input order.
//   Each input transaction is registered in every stage in turn before it
//   appears on out_ch. The 17 stages are one head cell that picks the sector
//   and the integer quotient bits, then 16 cells that each produce one
//   fraction bit of hue and of saturation. Throughput is one transaction per
//   cycle while out_ch is taken; the row holds up to 17 colors.
//   Each cell advances when it is empty or its neighbor takes its data, so
//   bubbles collapse and the row keeps accepting while the output waits,
//   until every cell is full. A stalled receiver holds out_ch unchanged.
//   Reset clears all cell valid flags; no results are pending afterwards.
//   Gray inputs (all channels equal) give hue and saturation of zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_convert_top (
  input  wire logic clk,
  input  wire logic rst_n,
  rgb_if.sink       in_ch,
  hsv_if.source     out_ch
);

  logic                  cell_valid [0:rhc_pkg::NUM_CELLS];
  logic                  cell_ready [0:rhc_pkg::NUM_CELLS];
  rhc_pkg::cell_data_t   cell_data  [0:rhc_pkg::NUM_CELLS];
  rhc_pkg::cell_data_t   last;

  rhc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_rgb   (in_ch.rgb_word),
    .dn_valid (cell_valid[0]),
    .dn_ready (cell_ready[0]),
    .dn_data  (cell_data[0])
  );

  for (genvar i = 0; i < rhc_pkg::NUM_CELLS; i++) begin : g_cell
    rhc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cell_valid[i]),
      .up_ready (cell_ready[i]),
      .up_data  (cell_data[i]),
      .dn_valid (cell_valid[i+1]),
      .dn_ready (cell_ready[i+1]),
      .dn_data  (cell_data[i+1])
    );
  end

  assign last                   = cell_data[rhc_pkg::NUM_CELLS];
  assign cell_ready[rhc_pkg::NUM_CELLS] = out_ch.ready;
  assign out_ch.valid           = cell_valid[rhc_pkg::NUM_CELLS];
  assign out_ch.hue_frac        = last.gray ? '0 : last.hue_q;
  assign out_ch.sat_frac        = last.gray ? '0 : {last.sat_int, last.sat_q};
  assign out_ch.value_level     = last.value;

  logic [rhc_pkg::CNT_W-1:0] inflight_r;
  logic [rhc_pkg::CNT_W-1:0] inflight_nxt;
  logic                      in_fire;
  logic                      out_fire;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_fire && !out_fire) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (out_fire && !in_fire) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= rhc_pkg::CNT_W'(rhc_pkg::DEPTH))
    else $error("more transactions in flight than cells");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready
                      && inflight_r == rhc_pkg::CNT_W'(rhc_pkg::DEPTH)))
    else $error("input stalled while the row has room");

  a_full_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.sat_frac[rhc_pkg::SAT_W-1]) |->
      (out_ch.sat_frac[rhc_pkg::FRAC_W-1:0] == '0))
    else $error("saturation above one");

  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.sat_frac == '0) |-> (out_ch.hue_frac == '0))
    else $error("gray color with nonzero hue");

endmodule

`default_nettype wire

>>> src/rhc_prep.sv
// ----------------------------------------------------------------------------
// rhc_prep
// Head cell: picks the sector, forms max, delta, the hue numerator and the
// integer quotient bits, and loads the first division remainders.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_prep (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       up_valid,
  output      logic                       up_ready,
  input  wire logic [rhc_pkg::RGB_W-1:0]  up_rgb,
  output      logic                       dn_valid,
  input  wire logic                       dn_ready,
  output      rhc_pkg::cell_data_t        dn_data
);

  logic                                valid_r;
  rhc_pkg::cell_data_t                 data_r;
  rhc_pkg::cell_data_t                 data_nxt;
  logic [rhc_pkg::CHAN_W-1:0]          r, g, b, hi, lo, delta;
  logic [rhc_pkg::HUE_DIV_W-1:0]       sixd;
  logic signed [rhc_pkg::HUE_DIV_W+1:0] num_s;
  logic [rhc_pkg::HUE_DIV_W-1:0]       num;
  logic                                load;

  assign r = up_rgb[3*rhc_pkg::CHAN_W-1 -: rhc_pkg::CHAN_W];
  assign g = up_rgb[2*rhc_pkg::CHAN_W-1 -: rhc_pkg::CHAN_W];
  assign b = up_rgb[rhc_pkg::CHAN_W-1 -: rhc_pkg::CHAN_W];

  always_comb begin
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    if (r >= g && r >= b) begin
      hi    = r;
      delta = r - lo;
      num_s = $signed({2'b00, 3'd0, delta} * 13'sd6) + $signed({5'd0, g}) - $signed({5'd0, b});
    end else if (g >= b) begin
      hi    = g;
      delta = g - lo;
      num_s = $signed({2'b00, 3'd0, delta} * 13'sd2) + $signed({5'd0, b}) - $signed({5'd0, r});
    end else begin
      hi    = b;
      delta = b - lo;
      num_s = $signed({2'b00, 3'd0, delta} * 13'sd4) + $signed({5'd0, r}) - $signed({5'd0, g});
    end
    sixd = rhc_pkg::HUE_DIV_W'({3'd0, delta} * 11'd6);
    num  = num_s[rhc_pkg::HUE_DIV_W-1:0];

    data_nxt.gray    = (delta == '0);
    data_nxt.hue_div = sixd;
    data_nxt.hue_rem = (num >= sixd) ? (num - sixd) : num;
    data_nxt.hue_q   = '0;
    data_nxt.value   = hi;
    data_nxt.sat_int = (delta >= hi);
    data_nxt.sat_rem = (delta >= hi) ? (delta - hi) : delta;
    data_nxt.sat_q   = '0;
  end

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

>>> src/rhc_cell.sv
// ----------------------------------------------------------------------------
// rhc_cell
// One restoring division step for hue and saturation: yields one fraction
// bit of each and hands the record to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 up_valid,
  output      logic                 up_ready,
  input  wire rhc_pkg::cell_data_t  up_data,
  output      logic                 dn_valid,
  input  wire logic                 dn_ready,
  output      rhc_pkg::cell_data_t  dn_data
);

  logic                             valid_r;
  rhc_pkg::cell_data_t              data_r;
  rhc_pkg::cell_data_t              data_nxt;
  logic [rhc_pkg::HUE_DIV_W:0]      hue_t;
  logic [rhc_pkg::CHAN_W:0]         sat_t;
  logic                             hue_bit;
  logic                             sat_bit;

  always_comb begin
    hue_t    = {up_data.hue_rem, 1'b0};
    sat_t    = {up_data.sat_rem, 1'b0};
    hue_bit  = (hue_t >= {1'b0, up_data.hue_div});
    sat_bit  = (sat_t >= {1'b0, up_data.value});
    data_nxt = up_data;
    data_nxt.hue_rem = hue_bit ? rhc_pkg::HUE_DIV_W'(hue_t - {1'b0, up_data.hue_div})
                               : hue_t[rhc_pkg::HUE_DIV_W-1:0];
    data_nxt.sat_rem = sat_bit ? rhc_pkg::CHAN_W'(sat_t - {1'b0, up_data.value})
                               : sat_t[rhc_pkg::CHAN_W-1:0];
    data_nxt.hue_q   = {up_data.hue_q[rhc_pkg::HUE_W-2:0], hue_bit};
    data_nxt.sat_q   = {up_data.sat_q[rhc_pkg::FRAC_W-2:0], sat_bit};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

>>> test/rgb_to_hsv_convert_top_test.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_top_test
// Self-checking bench for the RGB to HSV converter. Colors are streamed into
// in_ch and an integer model predicts hue, saturation and value for each
// accepted transaction. Results on out_ch are matched in order. The run covers
// directed corner colors and then random colors, under several sender and
// receiver idling mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_convert_top_test;

  localparam int unsigned PHASE_ITEMS  = 170;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned STUCK_LIMIT  = 4000;

  typedef struct packed {
    logic [rhc_pkg::RGB_W-1:0]  rgb;
    logic [rhc_pkg::HUE_W-1:0]  hue;
    logic [rhc_pkg::SAT_W-1:0]  sat;
    logic [rhc_pkg::CHAN_W-1:0] value;
  } hsv_expect_t;

  class color_board;
    hsv_expect_t expected[$];
    int unsigned faults = 0;

    function int unsigned pending();
      return expected.size();
    endfunction

    function void note_color(logic [rhc_pkg::RGB_W-1:0] rgb);
      logic [31:0] r, g, b, hi, lo, span, num, quo, sat_full;
      hsv_expect_t e;
      r  = {24'd0, rgb[23:16]};
      g  = {24'd0, rgb[15:8]};
      b  = {24'd0, rgb[7:0]};
      hi = (r > g) ? r : g;
      hi = (hi > b) ? hi : b;
      lo = (r < g) ? r : g;
      lo = (lo < b) ? lo : b;
      span = hi - lo;
      e = '0;
      e.rgb   = rgb;
      e.value = hi[rhc_pkg::CHAN_W-1:0];
      if (span != 0) begin
        if (hi == r) begin
          num = 6 * span + g - b;
        end else if (hi == g) begin
          num = 2 * span + b - r;
        end else begin
          num = 4 * span + r - g;
        end
        quo      = (num << 16) / (6 * span);
        sat_full = (span << 16) / hi;
        e.hue    = quo[rhc_pkg::HUE_W-1:0];
        e.sat    = sat_full[rhc_pkg::SAT_W-1:0];
      end
      expected.push_back(e);
    endfunction

    function void check_result(logic [rhc_pkg::HUE_W-1:0] hue,
                               logic [rhc_pkg::SAT_W-1:0] sat,
                               logic [rhc_pkg::CHAN_W-1:0] value);
      hsv_expect_t e;
      if (expected.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("ERROR: unexpected result hue=%0d sat=%0d value=%0d", hue, sat, value);
        return;
      end
      e = expected.pop_front();
      if (hue !== e.hue || sat !== e.sat || value !== e.value) begin
        faults++;
        if (faults <= 10)
          $display({"ERROR: rgb=%06h expected hue=%0d sat=%0d value=%0d",
                    " got hue=%0d sat=%0d value=%0d"},
                   e.rgb, e.hue, e.sat, e.value, hue, sat, value);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic hold_off = 1'b0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  event hold_go;

  color_board sb = new();

  rgb_if in_ch ();
  hsv_if out_ch ();

  rgb_to_hsv_convert_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [rhc_pkg::RGB_W-1:0] pick_color();
    logic [7:0] base, r, g, b;
    int unsigned sel;
    sel  = $urandom_range(99);
    base = 8'($urandom_range(255));
    r = 8'($urandom_range(255));
    g = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    if (sel < 8) begin
      r = base; g = base; b = base;
    end else if (sel < 14) begin
      r = base; g = base;
    end else if (sel < 20) begin
      g = base; b = base;
    end else if (sel < 26) begin
      r = base; b = base;
    end else if (sel < 36) begin
      r = base; g = base ^ 8'($urandom_range(3)); b = base ^ 8'($urandom_range(3));
    end else if (sel < 44) begin
      case ($urandom_range(2))
        0: r = 8'hff;
        1: g = 8'hff;
        default: b = 8'hff;
      endcase
      case ($urandom_range(2))
        0: r = 8'h00;
        1: g = 8'h00;
        default: b = 8'h00;
      endcase
    end
    return {r, g, b};
  endfunction

  task automatic send_color(input logic [rhc_pkg::RGB_W-1:0] rgb);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.rgb_word <= rhc_pkg::RGB_W'($urandom_range(32'hffffff));
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.rgb_word <= rgb;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (PHASE_ITEMS) send_color(pick_color());
  endtask

  // hold the receiver off while the sender keeps offering
  initial begin
    @(hold_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_color(in_ch.rgb_word);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.hue_frac, out_ch.sat_frac, out_ch.value_level);
    end
  end

  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("rgb_to_hsv_convert_top_test: FAIL");
    $finish;
  end

  initial begin
    logic [rhc_pkg::RGB_W-1:0] corner[$];
    corner = '{24'h000000, 24'hffffff, 24'h808080, 24'h010101, 24'hff0000,
               24'h00ff00, 24'h0000ff, 24'hffff00, 24'h00ffff, 24'hff00ff,
               24'hff0001, 24'hff0100, 24'h010000, 24'h000100, 24'h000001,
               24'hfeffff, 24'hff7f00, 24'h7fff80, 24'h102030, 24'h302010,
               24'hfffefe, 24'h800001, 24'h123456, 24'hfefeff, 24'h01ff00};
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.rgb_word <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner[i]) send_color(corner[i]);

    -> hold_go;
    run_phase(0, 0);
    run_phase(84, 0);
    run_phase(0, 84);
    run_phase(31, 31);
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("rgb_to_hsv_convert_top_test: PASS");
    end else begin
      $display("rgb_to_hsv_convert_top_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> rgb_to_hsv_convert_top.f
src/rhc_pkg.sv
src/rhc_if.sv
src/rhc_prep.sv
src/rhc_cell.sv
src/rgb_to_hsv_convert_top.sv
test/rgb_to_hsv_convert_top_test.sv
